// File: rtl/hpi_pkg.sv
// ----------------------------------------------------------------------------
// hpi_pkg: shared types and constants
// Command codes, fixed field widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hpi_pkg;

    localparam int POS_W      = 32;   // Q16.16 position width
    localparam int ANG_W      = 16;   // binary angle, 65536 = one turn
    localparam int CMD_W      = 2;
    localparam int DELTA_W    = 34;   // rounded CORDIC output, covers gain growth
    localparam int SUM_W      = 35;   // position plus delta before saturation
    localparam int ZW         = 33;   // residual angle, 2^32 = one turn
    localparam int MAX_STEPS  = 24;
    localparam int ATAN_IDX_W = 5;

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TURN = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

    // CORDIC gain 0.6072529350 in Q1.31
    localparam logic signed [31:0] GAIN_Q31 = 32'sh4DBA76D4;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

// File: rtl/hpi_if.sv
// ----------------------------------------------------------------------------
// hpi_cmd_if / hpi_pose_if: valid/ready channels
// Command channel into the integrator and pose channel out of it.
// ----------------------------------------------------------------------------
interface hpi_cmd_if
    import hpi_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic [ANG_W-1:0]        angle_value;
    logic signed [POS_W-1:0] distance;

    modport source (output valid, cmd, new_x, new_y, angle_value, distance, input ready);
    modport sink   (input valid, cmd, new_x, new_y, angle_value, distance, output ready);
endinterface

interface hpi_pose_if
    import hpi_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic [ANG_W-1:0]        pose_heading;
    logic                    clipped;

    modport source (output valid, pose_x, pose_y, pose_heading, clipped, input ready);
    modport sink   (input valid, pose_x, pose_y, pose_heading, clipped, output ready);
endinterface

// File: rtl/hpi_cordic.sv
// ----------------------------------------------------------------------------
// hpi_cordic: iterative CORDIC move engine
// Prescales the distance by the CORDIC gain, folds the heading into the
// right half plane, rotates one step a cycle and rounds off the guard bits.
// ----------------------------------------------------------------------------
module hpi_cordic
    import hpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [POS_W-1:0]   distance,
    input  logic [ANG_W-1:0]          heading,
    output logic                      done,
    output logic signed [DELTA_W-1:0] dx,
    output logic signed [DELTA_W-1:0] dy
);

    localparam int W     = DELTA_W + FRAC_BITS;
    localparam int SHIFT = 31 - FRAC_BITS;
    localparam int NSTEP = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_LOAD = 2'd1;
    localparam logic [1:0] E_ITER = 2'd2;
    localparam logic [1:0] E_OUT  = 2'd3;

    logic [1:0]                state_reg;
    logic [ATAN_IDX_W-1:0]     cnt_reg;
    logic                      done_reg;
    logic signed [63:0]        prod_reg;
    logic                      fold_reg;
    logic [ANG_W-1:0]          hz_reg;
    logic signed [W-1:0]       vx_reg;
    logic signed [W-1:0]       vy_reg;
    logic signed [ZW-1:0]      z_reg;
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;

    logic signed [63:0]        prod;
    logic signed [63:0]        scaled;
    logic signed [W-1:0]       v0;
    logic signed [W-1:0]       sx;
    logic signed [W-1:0]       sy;
    logic signed [ZW-1:0]      at;
    logic signed [W-1:0]       rx;
    logic signed [W-1:0]       ry;
    logic signed [W-1:0]       half;

    assign prod   = distance * GAIN_Q31;
    assign scaled = prod_reg >>> SHIFT;
    assign v0     = scaled[W-1:0];
    assign sx     = vx_reg >>> cnt_reg;
    assign sy     = vy_reg >>> cnt_reg;
    assign at     = $signed({1'b0, ATAN_TURN[cnt_reg]});
    assign half   = W'(1) << (FRAC_BITS - 1);
    assign rx     = vx_reg + half;
    assign ry     = vy_reg + half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // deltas land in dx_reg/dy_reg on the E_OUT edge
            done_reg <= (state_reg == E_OUT);
            case (state_reg)
                E_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= E_LOAD;
                    end
                end
                E_LOAD:
                begin
                    cnt_reg   <= '0;
                    state_reg <= E_ITER;
                end
                E_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == ATAN_IDX_W'(NSTEP - 1))
                    begin
                        state_reg <= E_OUT;
                    end
                end
                E_OUT:
                begin
                    state_reg <= E_IDLE;
                end
                default:
                begin
                    state_reg <= E_IDLE;
                end
            endcase
        end
    end

    // datapath: no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == E_IDLE && start)
        begin
            prod_reg <= prod;
            // headings in the left half plane: negate start vector, rotate by half a turn
            fold_reg <= heading[15] ^ heading[14];
            hz_reg   <= heading ^ {heading[15] ^ heading[14], 15'b0};
        end
        if (state_reg == E_LOAD)
        begin
            vx_reg <= fold_reg ? -v0 : v0;
            vy_reg <= '0;
            z_reg  <= $signed({hz_reg[15], hz_reg, 16'b0});
        end
        if (state_reg == E_ITER)
        begin
            if (!z_reg[ZW-1])
            begin
                vx_reg <= vx_reg - sy;
                vy_reg <= vy_reg + sx;
                z_reg  <= z_reg - at;
            end
            else
            begin
                vx_reg <= vx_reg + sy;
                vy_reg <= vy_reg - sx;
                z_reg  <= z_reg + at;
            end
        end
        if (state_reg == E_OUT)
        begin
            dx_reg <= DELTA_W'(rx >>> FRAC_BITS);
            dy_reg <= DELTA_W'(ry >>> FRAC_BITS);
        end
    end

    assign done = done_reg;
    assign dx   = dx_reg;
    assign dy   = dy_reg;

endmodule

// File: rtl/heading_position_integrator_top.sv
// ----------------------------------------------------------------------------
// heading_position_integrator_top: planar dead-reckoning pose keeper
// Set, move and turn commands update an (x, y, heading) pose; each returns it.
// ----------------------------------------------------------------------------
// One command transaction is taken at a time; ready is high only while the
// sequencer is idle. Set, turn and no-op commands go straight from idle to
// the writeback state. A move first registers distance times the CORDIC
// gain in a 32x32 multiplier, loads the rotation start vector, runs the
// shared add/shift rotation stage for CORDIC_STEPS steps (at most MAX_STEPS)
// one step at a time, rounds off the guard bits and hands the deltas over;
// the writeback state then does the saturating position update. Every
// command returns exactly one pose transaction through an output register;
// if that register still holds an untaken result, the finished command
// waits in its writeback state. Positions are signed Q16.16 and saturate
// on a move, flagged by clipped; the heading wraps at one turn.
// FRAC_BITS sets the guard bits carried inside the rotation datapath.
// ----------------------------------------------------------------------------
module heading_position_integrator_top
    import hpi_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    hpi_cmd_if.sink     command,
    hpi_pose_if.source  pose
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;   // ready for a command transaction
    localparam logic [1:0] S_WAIT = 2'd1;   // move in flight in the CORDIC engine
    localparam logic [1:0] S_DONE = 2'd2;   // writeback into pose and output register

    logic [1:0]                state_reg;
    logic [1:0]                state_next;

    // pose state
    logic signed [POS_W-1:0]   x_reg;
    logic signed [POS_W-1:0]   y_reg;
    logic [ANG_W-1:0]          heading_reg;

    // latched command payload
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [POS_W-1:0]   nx_reg;
    logic signed [POS_W-1:0]   ny_reg;
    logic [ANG_W-1:0]          ang_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [POS_W-1:0]   ox_reg;
    logic signed [POS_W-1:0]   oy_reg;
    logic [ANG_W-1:0]          oh_reg;
    logic                      oclip_reg;

    logic                      accept;
    logic                      out_free;
    logic                      write_back;
    logic                      eng_start;
    logic                      eng_done;
    logic signed [DELTA_W-1:0] eng_dx;
    logic signed [DELTA_W-1:0] eng_dy;

    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [POS_W-1:0]   sat_x;
    logic signed [POS_W-1:0]   sat_y;
    logic                      clip_x;
    logic                      clip_y;

    logic signed [POS_W-1:0]   x_next;
    logic signed [POS_W-1:0]   y_next;
    logic [ANG_W-1:0]          heading_next;
    logic                      clip_next;

    assign command.ready = (state_reg == S_IDLE);
    assign accept        = command.valid && command.ready;
    assign eng_start     = accept && (command.cmd == CMD_MOVE);
    assign out_free      = !out_valid_reg || pose.ready;
    assign write_back    = (state_reg == S_DONE) && out_free;

    hpi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (eng_start),
        .distance (command.distance),
        .heading  (heading_reg),
        .done     (eng_done),
        .dx       (eng_dx),
        .dy       (eng_dy)
    );

    // saturating position update; overflow when the top bits disagree
    assign sum_x = {{(SUM_W - POS_W){x_reg[POS_W-1]}}, x_reg}
                 + {{(SUM_W - DELTA_W){eng_dx[DELTA_W-1]}}, eng_dx};
    assign sum_y = {{(SUM_W - POS_W){y_reg[POS_W-1]}}, y_reg}
                 + {{(SUM_W - DELTA_W){eng_dy[DELTA_W-1]}}, eng_dy};

    always_comb
    begin
        clip_x = (sum_x[SUM_W-1:POS_W-1] != '0) && (sum_x[SUM_W-1:POS_W-1] != '1);
        clip_y = (sum_y[SUM_W-1:POS_W-1] != '0) && (sum_y[SUM_W-1:POS_W-1] != '1);
        if (!clip_x)
            sat_x = sum_x[POS_W-1:0];
        else if (sum_x[SUM_W-1])
            sat_x = {1'b1, {(POS_W-1){1'b0}}};
        else
            sat_x = {1'b0, {(POS_W-1){1'b1}}};
        if (!clip_y)
            sat_y = sum_y[POS_W-1:0];
        else if (sum_y[SUM_W-1])
            sat_y = {1'b1, {(POS_W-1){1'b0}}};
        else
            sat_y = {1'b0, {(POS_W-1){1'b1}}};
    end

    // pose after the latched command
    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        heading_next = heading_reg;
        clip_next    = 1'b0;
        case (cmd_reg)
            CMD_SET:
            begin
                x_next       = nx_reg;
                y_next       = ny_reg;
                heading_next = ang_reg;
            end
            CMD_MOVE:
            begin
                x_next    = sat_x;
                y_next    = sat_y;
                clip_next = clip_x || clip_y;
            end
            CMD_TURN:
            begin
                heading_next = heading_reg + ang_reg;   // wraps at one turn
            end
            default:
            begin
                // no-op: pose returned unchanged
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (command.cmd == CMD_MOVE) ? S_WAIT : S_DONE;
            end
            S_WAIT:
            begin
                if (eng_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (write_back)
            begin
                x_reg         <= x_next;
                y_reg         <= y_next;
                heading_reg   <= heading_next;
                out_valid_reg <= 1'b1;
            end
            else if (pose.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command.cmd;
            nx_reg  <= command.new_x;
            ny_reg  <= command.new_y;
            ang_reg <= command.angle_value;
        end
        if (write_back)
        begin
            ox_reg    <= x_next;
            oy_reg    <= y_next;
            oh_reg    <= heading_next;
            oclip_reg <= clip_next;
        end
    end

    assign pose.valid        = out_valid_reg;
    assign pose.pose_x       = ox_reg;
    assign pose.pose_y       = oy_reg;
    assign pose.pose_heading = oh_reg;
    assign pose.clipped      = oclip_reg;

endmodule

// File: rtl/hpi_checker.sv
// ----------------------------------------------------------------------------
// hpi_checker: port-level assertions for the pose integrator
// Watches the command and pose channels; bound to the top level.
// ----------------------------------------------------------------------------
module hpi_checker
    import hpi_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [POS_W-1:0] pose_x,
    input logic signed [POS_W-1:0] pose_y,
    input logic [ANG_W-1:0]        pose_heading,
    input logic                    clipped
);

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // heading of the last delivered pose; a move never changes it
    logic [ANG_W-1:0] last_heading_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_heading_reg <= '0;
        else if (out_valid && out_ready)
            last_heading_reg <= pose_heading;
    end

    // one command at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("command accepted while previous one in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pose transaction dropped before taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pose_x) && $stable(pose_y)
                                    && $stable(pose_heading) && $stable(clipped))
        else $error("stalled pose payload changed");

    a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> (pose_x == POS_MAX) || (pose_x == POS_MIN)
                                 || (pose_y == POS_MAX) || (pose_y == POS_MIN))
        else $error("clipped set without a saturated coordinate");

    a_clip_keeps_heading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |-> pose_heading == last_heading_reg)
        else $error("clipped result changed the heading");

endmodule

bind heading_position_integrator_top hpi_checker u_hpi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (command.valid),
    .in_ready     (command.ready),
    .out_valid    (pose.valid),
    .out_ready    (pose.ready),
    .pose_x       (pose.pose_x),
    .pose_y       (pose.pose_y),
    .pose_heading (pose.pose_heading),
    .clipped      (pose.clipped)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for heading_position_integrator_top
// Drives set, move, turn and no-op command transactions. It predicts every
// pose with a bit-exact CORDIC dead-reckoning model and checks each returned
// pose transaction in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import hpi_pkg::*;

    // DUT configuration, mirrored by the pose predictor below
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int STALL_LIMIT   = 2000;  // cycles with no transaction on either channel
    localparam int SETTLE_CYCLES = 40;    // > one move plus slack
    localparam int PHASE_ITEMS   = 579;
    localparam int MAX_REPORTS   = 200;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;

    localparam logic signed [POS_W-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [POS_W-1:0] Q_HUNDRED = 32'sh0064_0000;
    localparam logic signed [POS_W-1:0] S32_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] S32_MIN   = 32'sh8000_0000;

    // quadrant edges and wrap points of the binary angle
    localparam logic [ANG_W-1:0] ANGLE_CORNERS [8] = '{
        16'd0, 16'd16383, 16'd16384, 16'd32767,
        16'd32768, 16'd49151, 16'd49152, 16'd65535
    };

    typedef struct {
        logic [CMD_W-1:0]        op;
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic [ANG_W-1:0]        angle_value;
        logic signed [POS_W-1:0] distance;
    } command_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [ANG_W-1:0]        heading;
        logic                    clipped;
    } pose_t;

    logic clk;
    logic rst_n;

    hpi_cmd_if  command_bus ();
    hpi_pose_if pose_bus ();

    heading_position_integrator_top #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command_bus),
        .pose    (pose_bus)
    );

    // predictor state: the pose the DUT should hold after every accepted command
    logic signed [POS_W-1:0] model_x       = '0;
    logic signed [POS_W-1:0] model_y       = '0;
    logic [ANG_W-1:0]        model_heading = '0;

    pose_t pending_poses [$];     // expected pose transactions, oldest first

    int mismatch_count = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int clip_count     = 0;
    int op_count [4]   = '{0, 0, 0, 0};
    int send_idle_pct  = 0;       // chance in 100 that the command side idles a cycle
    int recv_idle_pct  = 0;       // chance in 100 that the pose side stalls a cycle
    int stall_cycles   = 0;

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Pose predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_s32(longint s);
        if (s > POS_MAX)
            return POS_MAX;
        if (s < POS_MIN)
            return POS_MIN;
        return s;
    endfunction

    // Applies one command to the predictor state and returns the pose it yields.
    function automatic pose_t advance_pose(command_t c);
        pose_t       p;
        longint      vx;
        longint      vy;
        longint      z;
        longint      sx;
        longint      sy;
        longint      sum_x;
        longint      sum_y;
        int unsigned h;
        int          steps;
        p.clipped = 1'b0;
        case (c.op)
            CMD_SET:
            begin
                model_x       = c.new_x;
                model_y       = c.new_y;
                model_heading = c.angle_value;
            end
            CMD_MOVE:
            begin
                // prescale by the CORDIC gain, keep FRAC_BITS guard bits
                vx = (longint'(c.distance) * longint'(GAIN_Q31)) >>> (31 - FRAC_BITS);
                vy = 0;
                h  = model_heading;
                // fold the left half-plane onto the right by negating the vector
                if (h >= 16384 && h <= 49151)
                begin
                    vx = -vx;
                    h  = (h + 32768) & 32'hFFFF;
                end
                z = (h >= 32768) ? longint'(h) - 65536 : longint'(h);
                z = z * 65536;
                steps = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
                for (int i = 0; i < steps; i++)
                begin
                    sx = vx >>> i;
                    sy = vy >>> i;
                    if (z >= 0)
                    begin
                        vx = vx - sy;
                        vy = vy + sx;
                        z  = z - longint'(ATAN_TURN[i]);
                    end
                    else
                    begin
                        vx = vx + sy;
                        vy = vy - sx;
                        z  = z + longint'(ATAN_TURN[i]);
                    end
                end
                // round off the guard bits, then saturating accumulate
                sum_x = longint'(model_x)
                      + ((vx + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
                sum_y = longint'(model_y)
                      + ((vy + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);
                if (clamp_s32(sum_x) != sum_x || clamp_s32(sum_y) != sum_y)
                    p.clipped = 1'b1;
                model_x = clamp_s32(sum_x);
                model_y = clamp_s32(sum_y);
            end
            CMD_TURN:
                model_heading = model_heading + c.angle_value;   // wraps at one turn
            default:
                ;   // no-op: pose unchanged
        endcase
        p.x       = model_x;
        p.y       = model_y;
        p.heading = model_heading;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic command_t make_cmd(logic [CMD_W-1:0] op,
                                          logic signed [POS_W-1:0] x,
                                          logic signed [POS_W-1:0] y,
                                          logic [ANG_W-1:0] ang,
                                          logic signed [POS_W-1:0] travel);
        command_t c;
        c.op          = op;
        c.new_x       = x;
        c.new_y       = y;
        c.angle_value = ang;
        c.distance    = travel;
        return c;
    endfunction

    // Q16.16 value: full range, scaled down, near a rail, or tiny
    function automatic logic signed [POS_W-1:0] random_q16();
        logic signed [POS_W-1:0] r;
        r = $urandom;
        case ($urandom_range(3))
            0: ;
            1: r = r >>> $urandom_range(4, 20);
            2: r = r[31] ? S32_MIN + $urandom_range(1 << 20) : S32_MAX - $urandom_range(1 << 20);
            default: r = $signed($urandom_range(8)) - 4;
        endcase
        return r;
    endfunction

    function automatic logic [ANG_W-1:0] random_angle();
        if ($urandom_range(3) == 0)
            return ANGLE_CORNERS[$urandom_range(7)];
        return ANG_W'($urandom_range(65535));
    endfunction

    // Mostly moves and turns; sets often enough to pull the pose off the rails.
    function automatic command_t random_command();
        command_t c;
        int       pick;
        pick          = $urandom_range(99);
        c.new_x       = random_q16();
        c.new_y       = random_q16();
        c.angle_value = random_angle();
        c.distance    = random_q16();
        if (pick < 14)
            c.op = CMD_SET;
        else if (pick < 64)
            c.op = CMD_MOVE;
        else if (pick < 93)
            c.op = CMD_TURN;
        else
            c.op = CMD_NOP;
        return c;
    endfunction

    // Sends one command transaction. Valid stays high afterwards so that
    // back-to-back commands follow without a gap; the next call lowers it
    // only when it decides to idle.
    task automatic send_cmd(input command_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            command_bus.valid <= 1'b0;
            @(posedge clk);
        end
        command_bus.valid       <= 1'b1;
        command_bus.cmd         <= c.op;
        command_bus.new_x       <= c.new_x;
        command_bus.new_y       <= c.new_y;
        command_bus.angle_value <= c.angle_value;
        command_bus.distance    <= c.distance;
        do
            @(posedge clk);
        while (!command_bus.ready);
        sent_count++;
        op_count[c.op]++;
        pending_poses.push_back(advance_pose(c));
    endtask

    // Command side goes quiet until every expected pose has come back.
    task automatic hold_until_drained();
        command_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_poses.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // A no-op right after reset must return the cleared pose.
    task automatic test_reset_pose();
        send_cmd(make_cmd(CMD_NOP, S32_MAX, S32_MIN, 16'hFFFF, S32_MAX));
    endtask

    task automatic test_set_extremes();
        send_cmd(make_cmd(CMD_SET, S32_MIN, S32_MAX, 16'd0, S32_MIN));
        send_cmd(make_cmd(CMD_SET, S32_MAX, S32_MIN, 16'hFFFF, S32_MAX));
        send_cmd(make_cmd(CMD_SET, '0, '0, 16'd0, '0));
    endtask

    // Heading wraps modulo one turn in both directions.
    task automatic test_turn_wrap();
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'hFFFF, '0));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd1, '0));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd32768, '0));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd32768, '0));
    endtask

    // Walks the heading across each fold boundary, moving at every stop.
    task automatic test_move_quadrants();
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, Q_HUNDRED));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd16383, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, -Q_HUNDRED));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd1, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, S32_MAX));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd16384, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, S32_MIN));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd16383, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, '0));
        send_cmd(make_cmd(CMD_TURN, '0, '0, 16'd1, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, Q_ONE + (Q_ONE >>> 1)));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, 32'sd1));
    endtask

    // Moves that push x past the top rail and y past the bottom rail.
    task automatic test_saturation();
        send_cmd(make_cmd(CMD_SET, S32_MAX - 5, '0, 16'd0, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, S32_MAX));
        send_cmd(make_cmd(CMD_SET, '0, S32_MIN, 16'd49152, '0));
        send_cmd(make_cmd(CMD_MOVE, '0, '0, '0, S32_MAX));
    endtask

    task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
        hold_until_drained();
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        repeat (count)
            send_cmd(random_command());
    endtask

    // ------------------------------------------------------------------------
    // Pose sink: random backpressure, in-order check against the predictor
    // ------------------------------------------------------------------------
    always @(posedge clk)
        pose_bus.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : pose_check
        pose_t want;
        if (rst_n && pose_bus.valid && pose_bus.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected pose transaction x=%h y=%h hdg=%h clip=%b",
                             $time, pose_bus.pose_x, pose_bus.pose_y,
                             pose_bus.pose_heading, pose_bus.clipped);
            end
            else
            begin
                want = pending_poses.pop_front();
                checked_count++;
                if (want.clipped)
                    clip_count++;
                if (pose_bus.pose_x !== want.x || pose_bus.pose_y !== want.y ||
                    pose_bus.pose_heading !== want.heading ||
                    pose_bus.clipped !== want.clipped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t ns: pose mismatch: expected x=%h y=%h hdg=%h clip=%b,",
                                  " actual x=%h y=%h hdg=%h clip=%b"},
                                 $time, want.x, want.y, want.heading, want.clipped,
                                 pose_bus.pose_x, pose_bus.pose_y,
                                 pose_bus.pose_heading, pose_bus.clipped);
                end
            end
        end
    end

    // Watchdog: any transaction on either channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (command_bus.valid && command_bus.ready) ||
            (pose_bus.valid && pose_bus.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: watchdog expired, %0d poses still expected",
                     $time, pending_poses.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n                   = 1'b0;
        command_bus.valid       = 1'b0;
        command_bus.cmd         = CMD_NOP;
        command_bus.new_x       = '0;
        command_bus.new_y       = '0;
        command_bus.angle_value = '0;
        command_bus.distance    = '0;
        pose_bus.ready          = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part runs under the first idle pattern
        send_idle_pct = 16;
        recv_idle_pct = 76;
        test_reset_pose();
        test_set_extremes();
        test_turn_wrap();
        test_move_quadrants();
        test_saturation();

        // random traffic: slow sink, then slow source, then full rate
        test_random_traffic(PHASE_ITEMS, 16, 76);
        test_random_traffic(PHASE_ITEMS, 76, 16);
        test_random_traffic(PHASE_ITEMS, 0, 0);

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d set, %0d move, %0d turn, %0d no-op.",
                 sent_count, op_count[CMD_SET], op_count[CMD_MOVE],
                 op_count[CMD_TURN], op_count[CMD_NOP]);
        $display("Checked %0d poses, %0d of them saturated; %0d mismatches.",
                 checked_count, clip_count, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: heading_position_integrator_top.f
rtl/hpi_pkg.sv
rtl/hpi_if.sv
rtl/hpi_cordic.sv
rtl/heading_position_integrator_top.sv
rtl/hpi_checker.sv
tb/tb_top.sv
